/* design/bsq_pkg.sv */
// ----------------------------------------------------------------------------
// bsq_pkg
// Shared types and constants for the bounded sorted priority queue.
// ----------------------------------------------------------------------------
package bsq_pkg;

	localparam int unsigned CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

	localparam logic FUNC_INSERT  = 1'b0;
	localparam logic FUNC_EXTRACT = 1'b1;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_DROPPED   = 2'd1,
		ST_EXTRACTED = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	// operation applied to every cell in the same cycle
	typedef struct packed {
		logic ins;
		logic ext;
	} cmd_t;

endpackage

/* design/bsq_cell.sv */
// ----------------------------------------------------------------------------
// bsq_cell
// One slot of the sorted shift chain: holds an entry, keeps it, takes the
// new entry, takes its left neighbour's entry on insert or its right
// neighbour's entry on extract.
// ----------------------------------------------------------------------------
module bsq_cell #(
	parameter int unsigned RANK_BITS = 8,
	parameter int unsigned TAG_BITS  = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bsq_pkg::cmd_t        cmd,
	input  logic [RANK_BITS-1:0] new_rank,
	input  logic [TAG_BITS-1:0]  new_tag,
	input  logic                 left_valid,
	input  logic                 left_keep,
	input  logic [RANK_BITS-1:0] left_rank,
	input  logic [TAG_BITS-1:0]  left_tag,
	input  logic                 right_valid,
	input  logic [RANK_BITS-1:0] right_rank,
	input  logic [TAG_BITS-1:0]  right_tag,
	output logic                 valid,
	output logic                 keep,
	output logic [RANK_BITS-1:0] rank,
	output logic [TAG_BITS-1:0]  tag
);

	logic                 valid_q;
	logic [RANK_BITS-1:0] rank_q;
	logic [TAG_BITS-1:0]  tag_q;

	// ties stay ahead of the new entry
	assign keep  = valid_q && (rank_q >= new_rank);
	assign valid = valid_q;
	assign rank  = rank_q;
	assign tag   = tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.ins) begin
			valid_q <= valid_q | left_valid;
		end else if (cmd.ext) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins && !keep) begin
			if (left_keep) begin
				rank_q <= new_rank;
				tag_q  <= new_tag;
			end else begin
				rank_q <= left_rank;
				tag_q  <= left_tag;
			end
		end else if (cmd.ext) begin
			rank_q <= right_rank;
			tag_q  <= right_tag;
		end
	end

endmodule

/* design/bounded_sorted_priority_queue_top.sv */
// ----------------------------------------------------------------------------
// bounded_sorted_priority_queue_top
// Bounded priority queue kept sorted by rank in a chain of shift cells.
// ----------------------------------------------------------------------------
// Commands enter on start with func, rank and tag; busy stays low, so a
// command is taken on every cycle that start is high.
// func insert places the entry behind all entries of equal or higher rank;
// func extract removes the head entry. Every cell compares and shifts in
// the same cycle, so one command per cycle is sustained.
// Each command gives one result beat in the next cycle: done is high for one
// cycle with status, out_tag, out_rank and occupancy. The receiver cannot
// stall, so the result must be taken in that cycle.
// Inserts beyond min(capacity, DEPTH) entries are dropped with a status.
// capacity is written through wr_en and wr_data; the user must write it only
// while no command is in flight (not enforced); capacity resets to 10.
// Reset empties the queue at once (cell valid bits clear); there is no
// clearing pass.
// ----------------------------------------------------------------------------
module bounded_sorted_priority_queue_top #(
	parameter int unsigned DEPTH     = 16,
	parameter int unsigned RANK_BITS = 8,
	parameter int unsigned TAG_BITS  = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        func,
	input  logic [RANK_BITS-1:0]        rank,
	input  logic [TAG_BITS-1:0]         tag,
	input  logic                        wr_en,
	input  logic [bsq_pkg::CAP_W-1:0]   wr_data,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [TAG_BITS-1:0]         out_tag,
	output logic [RANK_BITS-1:0]        out_rank,
	output logic [$clog2(DEPTH+1)-1:0]  occupancy
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned CMP_W = (CNT_W > bsq_pkg::CAP_W) ? CNT_W : bsq_pkg::CAP_W;

	logic [bsq_pkg::CAP_W-1:0] cap_q;
	logic [CNT_W-1:0]          count_q;
	logic                      done_q;
	bsq_pkg::status_t          status_q;
	logic [TAG_BITS-1:0]       out_tag_q;
	logic [RANK_BITS-1:0]      out_rank_q;
	logic [CNT_W-1:0]          occ_q;

	logic                      accept;
	logic                      full;
	logic                      empty;
	bsq_pkg::cmd_t             cmd;
	logic [CNT_W-1:0]          count_d;
	bsq_pkg::status_t          status_d;

	logic [DEPTH-1:0]          cell_valid;
	logic [DEPTH-1:0]          cell_keep;
	logic [RANK_BITS-1:0]      cell_rank [DEPTH];
	logic [TAG_BITS-1:0]       cell_tag  [DEPTH];

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign empty  = !cell_valid[0];
	assign full   = (CMP_W'(count_q) >= CMP_W'(cap_q)) || (count_q == CNT_W'(DEPTH));

	always_comb begin
		cmd.ins  = 1'b0;
		cmd.ext  = 1'b0;
		count_d  = count_q;
		status_d = bsq_pkg::ST_EMPTY;
		if (func == bsq_pkg::FUNC_INSERT) begin
			if (full) begin
				status_d = bsq_pkg::ST_DROPPED;
			end else begin
				status_d = bsq_pkg::ST_INSERTED;
				cmd.ins  = accept;
				count_d  = count_q + CNT_W'(1);
			end
		end else if (!empty) begin
			status_d = bsq_pkg::ST_EXTRACTED;
			cmd.ext  = accept;
			count_d  = count_q - CNT_W'(1);
		end
	end

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			logic                 lv;
			logic                 lk;
			logic [RANK_BITS-1:0] lr;
			logic [TAG_BITS-1:0]  lt;
			logic                 rv;
			logic [RANK_BITS-1:0] rr;
			logic [TAG_BITS-1:0]  rt;

			if (g == 0) begin : g_head
				assign lv = 1'b1;
				assign lk = 1'b1;
				assign lr = '0;
				assign lt = '0;
			end else begin : g_body
				assign lv = cell_valid[g-1];
				assign lk = cell_keep[g-1];
				assign lr = cell_rank[g-1];
				assign lt = cell_tag[g-1];
			end

			if (g == DEPTH - 1) begin : g_tail
				assign rv = 1'b0;
				assign rr = '0;
				assign rt = '0;
			end else begin : g_inner
				assign rv = cell_valid[g+1];
				assign rr = cell_rank[g+1];
				assign rt = cell_tag[g+1];
			end

			bsq_cell #(
				.RANK_BITS (RANK_BITS),
				.TAG_BITS  (TAG_BITS)
			) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.cmd         (cmd),
				.new_rank    (rank),
				.new_tag     (tag),
				.left_valid  (lv),
				.left_keep   (lk),
				.left_rank   (lr),
				.left_tag    (lt),
				.right_valid (rv),
				.right_rank  (rr),
				.right_tag   (rt),
				.valid       (cell_valid[g]),
				.keep        (cell_keep[g]),
				.rank        (cell_rank[g]),
				.tag         (cell_tag[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= bsq_pkg::CAP_RESET;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				cap_q <= wr_data;
			end
			if (accept) begin
				count_q <= count_d;
			end
			done_q <= accept;
		end
	end

	// result beat
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q   <= status_d;
			occ_q      <= count_d;
			out_tag_q  <= cmd.ext ? cell_tag[0] : '0;
			out_rank_q <= cmd.ext ? cell_rank[0] : '0;
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign out_tag   = out_tag_q;
	assign out_rank  = out_rank_q;
	assign occupancy = occ_q;

`ifndef SYNTHESIS
	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == int'(count_q))
		else $error("entry count differs from occupied cells");

	a_cells_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_valid & (cell_valid + DEPTH'(1))) == '0)
		else $error("occupied cells not packed at the head");

	a_beat_follows_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done && (occupancy == count_q))
		else $error("result beat missing or occupancy stale");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |-> (count_q < CNT_W'(DEPTH)) && !cell_valid[DEPTH-1])
		else $error("insert into a full chain");
`endif

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounded sorted priority queue. A shadow copy of
// the queue, kept sorted by rank with ties in arrival order, predicts the
// status, tag, rank and occupancy of every command. Directed commands cover
// the empty, full and tie cases. Random phases then follow at various
// capacities, with bursts of idle cycles on the command side.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH = 16;

	typedef struct {
		bsq_pkg::status_t st;
		logic [7:0]       tag;
		logic [7:0]       rank;
		logic [4:0]       occ;
	} queue_reply_t;

	class print_queue_shadow;
		logic [7:0]   held_rank[$];
		logic [7:0]   held_tag[$];
		logic [4:0]   capacity;
		queue_reply_t replies_due[$];
		int           errors;

		function new();
			capacity = bsq_pkg::CAP_RESET;
			errors = 0;
		endfunction

		function void set_capacity(logic [4:0] v);
			capacity = v;
		endfunction

		function int outstanding();
			return replies_due.size();
		endfunction

		function void note_command(logic f, logic [7:0] r, logic [7:0] t);
			queue_reply_t want;
			int           lim;
			int           pos;
			lim = (capacity > DEPTH) ? DEPTH : capacity;
			want.tag = '0;
			want.rank = '0;
			if (f == bsq_pkg::FUNC_INSERT) begin
				if (held_rank.size() >= lim) begin
					want.st = bsq_pkg::ST_DROPPED;
				end else begin
					pos = held_rank.size();
					for (int i = 0; i < held_rank.size(); i++) begin
						if (held_rank[i] < r) begin
							pos = i;
							break;
						end
					end
					held_rank.insert(pos, r);
					held_tag.insert(pos, t);
					want.st = bsq_pkg::ST_INSERTED;
				end
			end else if (held_rank.size() == 0) begin
				want.st = bsq_pkg::ST_EMPTY;
			end else begin
				want.st = bsq_pkg::ST_EXTRACTED;
				want.rank = held_rank.pop_front();
				want.tag = held_tag.pop_front();
			end
			want.occ = 5'(held_rank.size());
			replies_due.push_back(want);
		endfunction

		function void check_result(logic [1:0] st, logic [7:0] t, logic [7:0] r,
			logic [4:0] occ);
			queue_reply_t want;
			if (replies_due.size() == 0) begin
				$error("result beat with nothing outstanding: status %0d", st);
				errors++;
				return;
			end
			want = replies_due.pop_front();
			if (st !== want.st) begin
				$error("status: expected %0d, actual %0d", want.st, st);
				errors++;
			end
			if (t !== want.tag) begin
				$error("out_tag: expected %0d, actual %0d", want.tag, t);
				errors++;
			end
			if (r !== want.rank) begin
				$error("out_rank: expected %0d, actual %0d", want.rank, r);
				errors++;
			end
			if (occ !== want.occ) begin
				$error("occupancy: expected %0d, actual %0d", want.occ, occ);
				errors++;
			end
		endfunction

		function void flag_leftovers();
			if (replies_due.size() != 0) begin
				$error("%0d result beats never arrived", replies_due.size());
				errors += replies_due.size();
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic                      func;
	logic [7:0]                rank;
	logic [7:0]                tag;
	logic                      wr_en;
	logic [bsq_pkg::CAP_W-1:0] wr_data;
	logic                      done;
	logic [1:0]                status;
	logic [7:0]                out_tag;
	logic [7:0]                out_rank;
	logic [4:0]                occupancy;

	print_queue_shadow shadow = new();
	int                idle_odds;

	bounded_sorted_priority_queue_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.func      (func),
		.rank      (rank),
		.tag       (tag),
		.wr_en     (wr_en),
		.wr_data   (wr_data),
		.done      (done),
		.status    (status),
		.out_tag   (out_tag),
		.out_rank  (out_rank),
		.occupancy (occupancy)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// results first: a beat seen at this edge belongs to an earlier command
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (done === 1'b1)
				shadow.check_result(status, out_tag, out_rank, occupancy);
			if (start && !busy)
				shadow.note_command(func, rank, tag);
			if (wr_en)
				shadow.set_capacity(wr_data);
		end
	end

	task automatic send_cmd(logic f, logic [7:0] r, logic [7:0] t);
		@(negedge clk);
		start <= 1'b1;
		func <= f;
		rank <= r;
		tag <= t;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic pause(int n);
		@(negedge clk);
		start <= 1'b0;
		func <= 1'($urandom_range(0, 1));
		rank <= 8'($urandom_range(0, 255));
		tag <= 8'($urandom_range(0, 255));
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic drain();
		pause(1);
		while (shadow.outstanding() != 0)
			@(negedge clk);
	endtask

	task automatic write_capacity(logic [4:0] v);
		drain();
		@(negedge clk);
		wr_en <= 1'b1;
		wr_data <= v;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic random_cmd(int insert_pct);
		logic [7:0] r;
		if ($urandom_range(0, 3) == 0)
			r = 8'($urandom_range(0, 3) * 85);
		else
			r = 8'($urandom_range(0, 255));
		send_cmd(($urandom_range(1, 100) <= insert_pct) ?
			bsq_pkg::FUNC_INSERT : bsq_pkg::FUNC_EXTRACT,
			r, 8'($urandom_range(0, 255)));
		if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
			pause($urandom_range(1, 11));
	endtask

	initial begin
		#5_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	initial begin
		logic [4:0] caps[10];
		int         ins_pct;
		arst_n = 1'b0;
		start = 1'b0;
		func = bsq_pkg::FUNC_INSERT;
		rank = '0;
		tag = '0;
		wr_en = 1'b0;
		wr_data = '0;
		caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd0, 5'd2, 5'd16, 5'd0, 5'd12};
		caps[5] = 5'($urandom_range(0, 31));
		caps[8] = 5'($urandom_range(0, 31));
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty queue, reset capacity of ten, ties and drop when full
		send_cmd(bsq_pkg::FUNC_EXTRACT, 8'hff, 8'hff);
		send_cmd(bsq_pkg::FUNC_INSERT, 8'd0, 8'd0);
		send_cmd(bsq_pkg::FUNC_INSERT, 8'd255, 8'd255);
		send_cmd(bsq_pkg::FUNC_INSERT, 8'd128, 8'd1);
		send_cmd(bsq_pkg::FUNC_INSERT, 8'd128, 8'd2);
		send_cmd(bsq_pkg::FUNC_INSERT, 8'd128, 8'd3);
		send_cmd(bsq_pkg::FUNC_INSERT, 8'd255, 8'd7);
		send_cmd(bsq_pkg::FUNC_INSERT, 8'd0, 8'd9);
		send_cmd(bsq_pkg::FUNC_INSERT, 8'd200, 8'haa);
		send_cmd(bsq_pkg::FUNC_INSERT, 8'd60, 8'h55);
		send_cmd(bsq_pkg::FUNC_INSERT, 8'd128, 8'd4);
		send_cmd(bsq_pkg::FUNC_INSERT, 8'd100, 8'd5);
		send_cmd(bsq_pkg::FUNC_EXTRACT, 8'd0, 8'd0);
		send_cmd(bsq_pkg::FUNC_EXTRACT, 8'd0, 8'd0);
		send_cmd(bsq_pkg::FUNC_EXTRACT, 8'd0, 8'd0);
		// capacity below the count held
		write_capacity(5'd2);
		send_cmd(bsq_pkg::FUNC_INSERT, 8'd255, 8'd1);
		send_cmd(bsq_pkg::FUNC_EXTRACT, 8'd0, 8'd0);
		// capacity zero
		write_capacity(5'd0);
		send_cmd(bsq_pkg::FUNC_INSERT, 8'd1, 8'd1);
		send_cmd(bsq_pkg::FUNC_EXTRACT, 8'd0, 8'd0);

		for (int p = 0; p < 10; p++) begin
			write_capacity(caps[p]);
			ins_pct = (p % 2 == 0) ? $urandom_range(55, 85) : $urandom_range(20, 50);
			idle_odds = (p == 2 || p == 9) ? 0 : $urandom_range(2, 6);
			for (int i = 0; i < 150; i++) begin
				if (p == 4 && i == 75)
					drain();
				random_cmd(ins_pct);
			end
		end

		pause(1);
		for (int i = 0; i < 200 && shadow.outstanding() != 0; i++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		shadow.flag_leftovers();
		if (shadow.errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule
